@@ src/uv7_pkg.sv @@
package uv7_pkg;

  typedef struct packed {
    logic [63:0] w0;
    logic [63:0] w1;
  } rng_state_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_NANOS = 2'd1,
    ST_TS_RANGE  = 2'd2
  } status_t;

  // register map, indexed by paddr[3]
  localparam logic REG_SEED_A = 1'b0;
  localparam logic REG_SEED_B = 1'b1;

  localparam logic [63:0] GOLDEN_WORD  = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [3:0]  VERSION_NIB  = 4'h7;
  localparam logic [1:0]  VARIANT_BITS = 2'b10;
  localparam logic [47:0] MS_MAX       = 48'hFFFF_FFFF_FFFF;
  localparam logic [39:0] SEC_MAX      = 40'd281474976710;
  localparam logic [29:0] NANO_LIMIT   = 30'd1000000000;
  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;

  // floor(n / 1e6) == (n * RECIP) >> 50, exact for any 30-bit n
  localparam logic [30:0] NS_MS_RECIP  = 31'd1125899907;
  localparam int          NS_MS_SHIFT  = 50;

endpackage

@@ src/uv7_xoro.sv @@
module uv7_xoro (
  input  uv7_pkg::rng_state_t cur,
  output uv7_pkg::rng_state_t nxt,
  output logic [63:0]         word
);
  import uv7_pkg::*;

  logic [63:0] a;
  logic [63:0] b;

  assign a    = cur.w0;
  assign b    = cur.w1 ^ cur.w0;
  assign word = cur.w0 + cur.w1;

  // rotl 55, shift 14, rotl 36
  assign nxt.w0 = {a[8:0], a[63:9]} ^ b ^ {b[49:0], 14'b0};
  assign nxt.w1 = {b[27:0], b[63:28]};

endmodule

@@ src/uv7_time.sv @@
module uv7_time (
  input  logic [39:0] secs,
  input  logic        ns_present,
  input  logic [29:0] nanos,
  output logic [47:0] ms,
  output logic        nanos_bad,
  output logic        ts_bad
);
  import uv7_pkg::*;

  logic [60:0] ns_prod;
  logic [10:0] ns_ms;
  logic [49:0] sec_ms;
  logic [49:0] ms_wide;

  assign nanos_bad = nanos >= NANO_LIMIT;

  assign ns_prod = {31'b0, nanos} * {30'b0, NS_MS_RECIP};
  assign ns_ms   = ns_prod[NS_MS_SHIFT+10:NS_MS_SHIFT];
  assign sec_ms  = {10'b0, secs} * {40'b0, MS_PER_SEC};
  assign ms_wide = sec_ms + (ns_present ? {39'b0, ns_ms} : 50'b0);

  assign ts_bad = (secs > SEC_MAX) || (ms_wide > {2'b0, MS_MAX});
  assign ms     = ms_wide[47:0];

endmodule

@@ src/uuid_v7_generator.sv @@
// uuid_v7_generator: one 128-bit version-7 UUID for every request beat.
// Request channel: in_valid / in_stall with now_ms, ts_present,
// timestamp_seconds, ns_present, nanoseconds and reseed. Result channel:
// out_valid / out_stall with status, uuid_high and uuid_low.
// A beat taken on the request channel is held in the input register, then in
// the result register that drives the result port. Throughput: one beat per
// cycle while the result is not stalled; generator and monotonic state (two
// xoroshiro steps plus the 64-bit time compare) update between the registers.
// A stalled result holds; the input register still takes one more beat, and
// in_stall rises only when both registers are full.
// Reset clears seeds, generator state, monotonic state and the seeded flag;
// the first request after reset (or any with reseed set) loads the seeds and
// clears the monotonic counters, errors included.
// Errors: status 1 for nanoseconds of one billion or more, status 2 for a
// timestamp beyond 48 bits of ms; UUID reads zero, generator holds. Seeds are
// written over APB port 0x0 and 0x8 by the user only while idle; not enforced.
module uuid_v7_generator (
  input  logic        clk,
  input  logic        rst,
  // apb config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // request
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [47:0] now_ms,
  input  logic        ts_present,
  input  logic [39:0] timestamp_seconds,
  input  logic        ns_present,
  input  logic [29:0] nanoseconds,
  input  logic        reseed,
  // result
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] uuid_high,
  output logic [63:0] uuid_low
);
  import uv7_pkg::*;

  // config registers
  logic [63:0] seed_word_a;
  logic [63:0] seed_word_b;
  logic        cfg_wr;

  // input register
  logic        s1_valid;
  logic [47:0] s1_now;
  logic        s1_has_ts;
  logic [39:0] s1_secs;
  logic        s1_has_ns;
  logic [29:0] s1_nanos;
  logic        s1_reseed;

  // block state
  rng_state_t  rng;
  rng_state_t  rng_next;
  logic [63:0] last_millis;
  logic [63:0] last_millis_next;
  logic [11:0] seq_count;
  logic [11:0] seq_count_next;
  logic [61:0] tail_count;
  logic [61:0] tail_count_next;
  logic        seeded;

  // result register
  status_t     res_status;
  status_t     res_status_next;
  logic [63:0] res_high_next;
  logic [63:0] res_low_next;

  logic        out_load;
  logic        s1_fire;

  // working values
  logic        seeding;
  rng_state_t  rng_base;
  logic [63:0] lm_base;
  logic [11:0] seq_base;
  logic [61:0] tail_base;
  rng_state_t  step1_nxt;
  rng_state_t  step2_nxt;
  logic [63:0] draw1;
  logic [63:0] draw2;
  logic [47:0] ts_ms;
  logic        nanos_bad;
  logic        ts_bad;
  logic [47:0] ms;
  logic [11:0] rand_a;
  logic [61:0] tail;

  // ---------------- config port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3])
      REG_SEED_A: prdata = seed_word_a;
      REG_SEED_B: prdata = seed_word_b;
      default:    prdata = seed_word_a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_word_a <= '0;
      seed_word_b <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_SEED_A) seed_word_a <= pwdata;
      if (paddr[3] == REG_SEED_B) seed_word_b <= pwdata;
    end
  end

  // ---------------- handshake ----------------
  // result register frees when empty or being taken this edge
  assign out_load = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_load;
  assign in_stall = s1_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) s1_valid <= in_valid;
      if (out_load)  out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_now    <= now_ms;
      s1_has_ts <= ts_present;
      s1_secs   <= timestamp_seconds;
      s1_has_ns <= ns_present;
      s1_nanos  <= nanoseconds;
      s1_reseed <= reseed;
    end
  end

  // ---------------- datapath ----------------
  assign seeding = s1_reseed || !seeded;

  always_comb begin
    if (seeding) begin
      rng_base.w0 = seed_word_a;
      rng_base.w1 = ((seed_word_a | seed_word_b) == 64'b0) ? GOLDEN_WORD : seed_word_b;
      lm_base     = '0;
      seq_base    = '0;
      tail_base   = '0;
    end else begin
      rng_base  = rng;
      lm_base   = last_millis;
      seq_base  = seq_count;
      tail_base = tail_count;
    end
  end

  uv7_xoro u_step1 (
    .cur  (rng_base),
    .nxt  (step1_nxt),
    .word (draw1)
  );

  uv7_xoro u_step2 (
    .cur  (step1_nxt),
    .nxt  (step2_nxt),
    .word (draw2)
  );

  uv7_time u_time (
    .secs       (s1_secs),
    .ns_present (s1_has_ns),
    .nanos      (s1_nanos),
    .ms         (ts_ms),
    .nanos_bad  (nanos_bad),
    .ts_bad     (ts_bad)
  );

  always_comb begin
    rng_next         = rng_base;
    last_millis_next = lm_base;
    seq_count_next   = seq_base;
    tail_count_next  = tail_base;
    res_status_next  = ST_OK;
    ms               = s1_now;
    rand_a           = '0;
    tail             = '0;

    priority if (s1_has_ns && nanos_bad) begin
      res_status_next = ST_BAD_NANOS;
    end else if (s1_has_ts) begin
      if (ts_bad) begin
        res_status_next = ST_TS_RANGE;
      end else if (s1_has_ns) begin
        ms       = ts_ms;
        rand_a   = s1_nanos[11:0];
        tail     = draw1[61:0];
        rng_next = step1_nxt;
      end else begin
        ms       = ts_ms;
        rand_a   = draw1[11:0];
        tail     = draw2[61:0];
        rng_next = step2_nxt;
      end
    end else if (s1_has_ns) begin
      // nanos give rand_a, monotonic state untouched
      rand_a   = s1_nanos[11:0];
      tail     = draw1[61:0];
      rng_next = step1_nxt;
    end else begin
      if ({16'b0, s1_now} > lm_base) begin
        last_millis_next = {16'b0, s1_now};
        seq_count_next   = draw1[11:0];
        tail_count_next  = draw2[61:0];
        rng_next         = step2_nxt;
      end else begin
        if ({16'b0, s1_now} < lm_base) last_millis_next = lm_base + 64'd1;
        seq_count_next  = seq_base + 12'd1;
        tail_count_next = tail_base + 62'd1;
      end
      ms     = last_millis_next[47:0];
      rand_a = seq_count_next;
      tail   = tail_count_next;
    end

    if (res_status_next == ST_OK) begin
      res_high_next = {ms, VERSION_NIB, rand_a};
      res_low_next  = {VARIANT_BITS, tail};
    end else begin
      res_high_next = '0;
      res_low_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rng         <= '0;
      last_millis <= '0;
      seq_count   <= '0;
      tail_count  <= '0;
      seeded      <= 1'b0;
    end else if (s1_fire) begin
      rng         <= rng_next;
      last_millis <= last_millis_next;
      seq_count   <= seq_count_next;
      tail_count  <= tail_count_next;
      seeded      <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_status <= res_status_next;
      uuid_high  <= res_high_next;
      uuid_low   <= res_low_next;
    end
  end

  assign status = res_status;

  // ---------------- checks ----------------
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (uuid_high == 64'b0) && (uuid_low == 64'b0))
    else $error("error result carries a non-zero UUID");

  a_ok_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |->
      (uuid_high[15:12] == VERSION_NIB) && (uuid_low[63:62] == VARIANT_BITS))
    else $error("version or variant bits missing");

  a_seeded: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> seeded)
    else $error("generator not marked seeded after a request");

  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with a free register");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import uv7_pkg::*;

  // one request beat, one field per port
  typedef struct {
    logic [47:0] now_ms;
    logic        has_ts;
    logic [39:0] secs;
    logic        has_ns;
    logic [29:0] nanos;
    logic        reseed;
  } req_beat_t;

  // one result beat
  typedef struct {
    status_t     st;
    logic [63:0] hi;
    logic [63:0] lo;
  } uuid_beat_t;

  // directed stimulus row; typed rows carry a hand-written expectation
  typedef struct {
    req_beat_t  req;
    bit         typed;
    uuid_beat_t want;
  } stim_row_t;

  localparam int PHASE_BEATS = 80;
  localparam int HOLD_CYCLES = 64;   // long receiver hold-off
  localparam int HOLD_AT     = 150;  // result count at which it starts
  localparam int DRAIN_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [47:0] now_ms = '0;
  logic        ts_present = 1'b0;
  logic [39:0] timestamp_seconds = '0;
  logic        ns_present = 1'b0;
  logic [29:0] nanoseconds = '0;
  logic        reseed = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [63:0] uuid_high;
  logic [63:0] uuid_low;

  uuid_v7_generator dut (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .now_ms            (now_ms),
    .ts_present        (ts_present),
    .timestamp_seconds (timestamp_seconds),
    .ns_present        (ns_present),
    .nanoseconds       (nanoseconds),
    .reseed            (reseed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .uuid_high         (uuid_high),
    .uuid_low          (uuid_low)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: seed registers, xoroshiro128+ words, monotonic state
  // ---------------------------------------------------------------------
  logic [63:0] seed_a = '0;
  logic [63:0] seed_b = '0;
  logic [63:0] gen_s0 = '0;
  logic [63:0] gen_s1 = '0;
  logic [63:0] last_ms = '0;     // 64-bit wrapping, only low 48 bits shown
  logic [11:0] seq_cnt = '0;
  logic [61:0] tail_cnt = '0;
  bit          seeded = 1'b0;

  uuid_beat_t  pending_uuids[$];  // expected results, oldest first
  stim_row_t   directed_rows[$];
  int          mismatch_count = 0;
  int          beats_sent = 0;
  int          beats_seen = 0;
  bit          hold_active = 1'b0; // sender stops idling while set
  logic [47:0] wall_ms = 48'd1000;  // running clock for monotonic runs

  // xoroshiro128+ step: rotl 55, shift 14, rotl 36
  function automatic logic [63:0] next_rand();
    logic [63:0] a, b, sum;
    a = gen_s0;
    b = gen_s1;
    sum = a + b;
    b = b ^ a;
    gen_s0 = {a[8:0], a[63:9]} ^ b ^ (b << 14);
    gen_s1 = {b[27:0], b[63:28]};
    return sum;
  endfunction

  function automatic uuid_beat_t predict_uuid(req_beat_t r);
    uuid_beat_t  res;
    logic [63:0] ms, w;
    logic [11:0] ra;
    logic [61:0] tl;
    res.st = ST_OK;
    res.hi = '0;
    res.lo = '0;
    if (r.reseed) seeded = 1'b0;
    // seeding happens even when the beat turns out to be an error
    if (!seeded) begin
      gen_s0 = seed_a;
      gen_s1 = seed_b;
      if ((seed_a | seed_b) == 64'd0) gen_s1 = GOLDEN_WORD;
      last_ms = '0;
      seq_cnt = '0;
      tail_cnt = '0;
      seeded = 1'b1;
    end
    // nanos error outranks the timestamp range error
    if (r.has_ns && r.nanos >= NANO_LIMIT) begin
      res.st = ST_BAD_NANOS;
      return res;
    end
    if (r.has_ts) begin
      if (r.secs > SEC_MAX) begin
        res.st = ST_TS_RANGE;
        return res;
      end
      ms = 64'(r.secs) * 64'd1000;
      if (r.has_ns) ms = ms + 64'(r.nanos / 30'd1000000);
      if (ms > 64'(MS_MAX)) begin
        res.st = ST_TS_RANGE;
        return res;
      end
      if (r.has_ns) begin
        ra = r.nanos[11:0];
      end else begin
        w = next_rand();
        ra = w[11:0];
      end
      w = next_rand();
      tl = w[61:0];
    end else if (r.has_ns) begin
      // nanos with wall time: monotonic state left alone
      ms = 64'(r.now_ms);
      ra = r.nanos[11:0];
      w = next_rand();
      tl = w[61:0];
    end else begin
      if (64'(r.now_ms) > last_ms) begin
        last_ms = 64'(r.now_ms);
        w = next_rand();
        seq_cnt = w[11:0];
        w = next_rand();
        tail_cnt = w[61:0];
      end else begin
        if (64'(r.now_ms) < last_ms) last_ms = last_ms + 64'd1;
        seq_cnt = seq_cnt + 12'd1;
        tail_cnt = tail_cnt + 62'd1;
      end
      ms = last_ms;
      ra = seq_cnt;
      tl = tail_cnt;
    end
    res.hi = {ms[47:0], VERSION_NIB, ra};
    res.lo = {VARIANT_BITS, tl};
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %h want %h (result %0d)", $time, what, got, want,
             beats_seen);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------
  // APB write: setup then access; register takes the value at the access edge
  // ---------------------------------------------------------------------
  task automatic apb_write(logic idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (pready !== 1'b1);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SEED_A) seed_a = val;
    else seed_b = val;
  endtask

  // ---------------------------------------------------------------------
  // Request side. A random gap before each beat, none in every fourth window of 40 beats
  // and none while the receiver holds off, so the block backs up.
  // Acceptance is judged at the falling edge, where nothing moves.
  // ---------------------------------------------------------------------
  task automatic send_beat(req_beat_t r, bit typed, uuid_beat_t want);
    int         gap;
    uuid_beat_t pred;
    gap = (hold_active || ((beats_sent / 40) % 4 == 3)) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    now_ms            <= r.now_ms;
    ts_present        <= r.has_ts;
    timestamp_seconds <= r.secs;
    ns_present        <= r.has_ns;
    nanoseconds       <= r.nanos;
    reseed            <= r.reseed;
    do @(negedge clk); while (in_stall !== 1'b0);
    @(posedge clk);
    // beat taken at this edge; predictor runs even for typed rows
    pred = predict_uuid(r);
    pending_uuids.push_back(typed ? want : pred);
    beats_sent++;
  endtask

  // quiesce: drop valid, then wait for every expected result
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_uuids.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic void add_row(logic [47:0] n, logic ts, logic [39:0] s, logic hn,
                                  logic [29:0] ns, logic rs, bit typed, status_t st,
                                  logic [63:0] hi, logic [63:0] lo);
    stim_row_t row;
    row.req.now_ms = n;
    row.req.has_ts = ts;
    row.req.secs   = s;
    row.req.has_ns = hn;
    row.req.nanos  = ns;
    row.req.reseed = rs;
    row.typed      = typed;
    row.want.st    = st;
    row.want.hi    = hi;
    row.want.lo    = lo;
    directed_rows.push_back(row);
  endfunction

  // Random request: mostly monotonic runs around a moving wall clock, then
  // valid explicit timestamps, nanos-only beats, errors and raw noise.
  // Ignored fields always carry random junk.
  function automatic req_beat_t random_req();
    req_beat_t   r;
    int          pick, sub;
    logic [63:0] wide;
    wide     = {$urandom, $urandom};
    r.now_ms = wide[47:0];
    wide     = {$urandom, $urandom};
    r.secs   = wide[39:0];
    r.nanos  = 30'($urandom);
    r.has_ts = 1'($urandom);
    r.has_ns = 1'($urandom);
    r.reseed = ($urandom_range(0, 24) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.has_ts = 1'b0;
      r.has_ns = 1'b0;
      sub = $urandom_range(0, 9);
      if (sub < 5) begin
        wall_ms = wall_ms + 48'($urandom_range(1, 3));
        r.now_ms = wall_ms;
      end else if (sub < 7) begin
        r.now_ms = wall_ms;                          // same millisecond
      end else if (sub < 9) begin
        r.now_ms = wall_ms - 48'($urandom_range(1, 4)); // clock stepped back
      end else begin
        wide = {$urandom, $urandom};
        wall_ms = wide[47:0];
        r.now_ms = wall_ms;
      end
    end else if (pick < 70) begin
      r.has_ts = 1'b1;
      wide = {$urandom, $urandom};
      r.secs = 40'(wide % (64'(SEC_MAX) + 64'd1));
      r.nanos = 30'($urandom_range(0, 999999999));
    end else if (pick < 80) begin
      r.has_ts = 1'b0;
      r.has_ns = 1'b1;
      r.nanos = 30'($urandom_range(0, 999999999));
    end else if (pick < 90) begin
      if ($urandom_range(0, 1) == 1) begin
        r.has_ns = 1'b1;
        r.nanos = 30'($urandom_range(1000000000, 1073741823));
      end else begin
        r.has_ts = 1'b1;
        wide = {$urandom, $urandom};
        r.secs = 40'(64'(SEC_MAX) + 64'd1 + wide % (64'h100_0000_0000 - 64'(SEC_MAX) - 64'd1));
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: a random stall before each result, none in quiet windows, and
  // one long hold-off partway through the random part.
  // ---------------------------------------------------------------------
  initial begin : result_side
    int         hold;
    uuid_beat_t want;
    @(negedge rst);
    forever begin
      if (beats_seen == HOLD_AT) begin
        hold = HOLD_CYCLES;
        hold_active = 1'b1;
      end else begin
        hold = ((beats_seen / 40) % 4 == 1) ? 0 : $urandom_range(0, 5);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      hold_active = 1'b0;
      out_stall <= 1'b0;
      do @(negedge clk); while (out_valid !== 1'b1);
      // taken at the next rising edge; fields are settled here
      if (pending_uuids.size() == 0) begin
        report_mismatch("unexpected result, uuid_high", uuid_high, 64'd0);
      end else begin
        want = pending_uuids.pop_front();
        if (status !== want.st) report_mismatch("status", 64'(status), 64'(want.st));
        if (uuid_high !== want.hi) report_mismatch("uuid_high", uuid_high, want.hi);
        if (uuid_low !== want.lo) report_mismatch("uuid_low", uuid_low, want.lo);
      end
      beats_seen++;
      @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] plan_a [5];
    logic [63:0] plan_b [5];
    req_beat_t   r;
    uuid_beat_t  none;
    none.st = ST_OK;
    none.hi = '0;
    none.lo = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, seeds still at reset (both zero, so the golden word is
    // loaded). Typed rows: counters from a fresh seed, and error beats.
    add_row(48'd0, 0, 40'd0, 0, 30'd0, 0, 1, ST_OK, 64'h7001, 64'h8000_0000_0000_0001);
    add_row(48'd0, 0, 40'd0, 0, 30'd0, 0, 1, ST_OK, 64'h7002, 64'h8000_0000_0000_0002);
    add_row(MS_MAX, 0, 40'd0, 0, 30'd0, 0, 0, ST_OK, '0, '0);   // newer: redraw
    add_row(MS_MAX, 0, 40'd0, 0, 30'd0, 0, 0, ST_OK, '0, '0);   // equal: count up
    add_row(48'd5, 0, 40'd0, 0, 30'd0, 0, 0, ST_OK, '0, '0);    // older: bump past 48 bits
    add_row(48'd0, 0, 40'd0, 0, 30'd0, 0, 0, ST_OK, '0, '0);
    add_row(48'd77, 1, 40'd0, 0, 30'd0, 0, 0, ST_OK, '0, '0);   // explicit zero seconds
    add_row(48'd0, 1, SEC_MAX, 0, 30'd0, 0, 0, ST_OK, '0, '0);  // largest seconds
    add_row(48'd0, 1, SEC_MAX + 40'd1, 0, 30'd0, 0, 1, ST_TS_RANGE, '0, '0);
    add_row(48'd0, 1, 40'hFF_FFFF_FFFF, 0, 30'd0, 0, 1, ST_TS_RANGE, '0, '0);
    add_row(48'd0, 1, SEC_MAX, 1, 30'd999999999, 0, 1, ST_TS_RANGE, '0, '0);
    add_row(48'd0, 1, SEC_MAX, 1, 30'd655999999, 0, 0, ST_OK, '0, '0); // ms exactly at top
    add_row(48'd0, 1, SEC_MAX, 1, 30'd656000000, 0, 1, ST_TS_RANGE, '0, '0);
    add_row(48'd0, 1, 40'd5, 1, NANO_LIMIT, 0, 1, ST_BAD_NANOS, '0, '0);
    add_row(48'd0, 0, 40'd0, 1, 30'h3FFF_FFFF, 0, 1, ST_BAD_NANOS, '0, '0);
    // nanos error wins over an oversized timestamp
    add_row(48'd0, 1, 40'hFF_FFFF_FFFF, 1, NANO_LIMIT, 0, 1, ST_BAD_NANOS, '0, '0);
    add_row(48'h1234_5678_9ABC, 0, 40'd0, 1, 30'd999999999, 0, 0, ST_OK, '0, '0);
    // ignored fields full of ones
    add_row(MS_MAX, 0, 40'hFF_FFFF_FFFF, 0, 30'h3FFF_FFFF, 0, 0, ST_OK, '0, '0);
    // reseed on an error beat still clears the monotonic state
    add_row(48'd0, 0, 40'd0, 1, NANO_LIMIT, 1, 1, ST_BAD_NANOS, '0, '0);
    add_row(48'd0, 0, 40'd0, 0, 30'd0, 0, 1, ST_OK, 64'h7001, 64'h8000_0000_0000_0001);
    add_row(48'h0000_0000_1000, 0, 40'd0, 0, 30'd0, 1, 0, ST_OK, '0, '0);
    add_row(48'd0, 1, 40'd1, 1, 30'd0, 0, 0, ST_OK, '0, '0);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    drain();

    // seed settings per phase: zero pair, all ones, one word zero, random
    plan_a[0] = '0;             plan_b[0] = '0;
    plan_a[1] = '1;             plan_b[1] = '1;
    plan_a[2] = {$urandom, $urandom}; plan_b[2] = '0;
    plan_a[3] = '0;             plan_b[3] = {$urandom, $urandom};
    plan_a[4] = {$urandom, $urandom}; plan_b[4] = {$urandom, $urandom};

    for (int p = 0; p < 5; p++) begin
      apb_write(REG_SEED_A, plan_a[p]);
      apb_write(REG_SEED_B, plan_b[p]);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        r = random_req();
        if (k == 0) r.reseed = 1'b1;  // pick up the new seeds straight away
        send_beat(r, 1'b0, none);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    while (pending_uuids.size() != 0) begin
      none = pending_uuids.pop_front();
      report_mismatch("missing result, uuid_high", 64'd0, none.hi);
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
